@@ rtl/core/pefs_pkg.sv @@
// Shared types and constants for the pulse event frame serializer.
// Used by the front, queue, back and top-level modules; no dependencies.
package pefs_pkg;

  localparam logic [7:0] ByteEsc  = 8'h1B;
  localparam logic [7:0] ByteFlip = 8'h20;
  localparam logic [7:0] ByteSof  = 8'hFE;
  localparam logic [7:0] ByteEof  = 8'hFF;

  localparam logic FuncHeader = 1'b0;
  localparam logic FuncPiece  = 1'b1;

  // data bytes carried by one command, header is the longest
  localparam int unsigned CmdBytes   = 12;
  localparam int unsigned CntW       = $clog2(CmdBytes + 1);
  localparam logic [CntW-1:0] HdrBytes   = CntW'(12);
  localparam logic [CntW-1:0] PieceBytes = CntW'(3);

  localparam int unsigned QueueDepth = 2;

  // one frame section to serialize: optional start byte, data bytes
  // (first byte in the top bits), optional end byte
  typedef struct packed {
    logic                  sof;
    logic                  eof;
    logic [CntW-1:0]       cnt;
    logic [CmdBytes*8-1:0] data;
  } cmd_t;

  // queue status toward the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/core/pulse_event_frame_serializer.sv @@
// Pulse event frame serializer: header and piece items in, stuffed bytes out.
// An accepted item passes the queue and back end into the output register.
// Throughput: one output byte per cycle while out_ready_i is high and
// commands are queued, set by the single byte-wide output stage.
// Reset (rst_ni, async low): no frame open, queue and output stage empty.
// Depends on pefs_pkg, pefs_front, pefs_queue, pefs_back.
module pulse_event_frame_serializer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] evt_id_i,
  input  logic [7:0]  wait_trigger_i,
  input  logic [63:0] time_us_i,
  input  logic [7:0]  piece_count_i,
  input  logic [7:0]  piece_mode_i,
  input  logic [15:0] piece_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        last_o
);
  import pefs_pkg::*;

  cmd_t    push_cmd, head;
  q_stat_t q_stat;
  logic    push, pop;

  pefs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .evt_id_i       (evt_id_i),
    .wait_trigger_i (wait_trigger_i),
    .time_us_i      (time_us_i),
    .piece_count_i  (piece_count_i),
    .piece_mode_i   (piece_mode_i),
    .piece_ticks_i  (piece_ticks_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  pefs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  pefs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .last_o      (last_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full))
    else $error("command pushed into full queue");

  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_stat.empty))
    else $error("command popped from empty queue");

  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> out_byte_o == ByteEof && last_o)
    else $error("frame end marker is not a final 0xFF byte");

endmodule

@@ rtl/core/pefs_front.sv @@
// Front end: accepts items, tracks the open frame and builds commands.
// Depends on pefs_pkg.
module pefs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [15:0]          evt_id_i,
  input  logic [7:0]           wait_trigger_i,
  input  logic [63:0]          time_us_i,
  input  logic [7:0]           piece_count_i,
  input  logic [7:0]           piece_mode_i,
  input  logic [15:0]          piece_ticks_i,
  input  pefs_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output pefs_pkg::cmd_t       cmd_o
);
  import pefs_pkg::*;

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic       accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    open_d = open_q;
    left_d = left_q;
    push_o = 1'b0;
    cmd_o  = '0;
    if (accept) begin
      unique case (func_i)
        FuncHeader: begin
          push_o   = 1'b1;
          cmd_o.sof  = 1'b1;
          cmd_o.eof  = (piece_count_i == 8'd0);
          cmd_o.cnt  = HdrBytes;
          cmd_o.data = {evt_id_i, wait_trigger_i, time_us_i, piece_count_i};
          open_d   = (piece_count_i != 8'd0);
          left_d   = piece_count_i;
        end
        FuncPiece: begin
          // drop pieces that arrive with no frame open
          if (open_q) begin
            push_o     = 1'b1;
            cmd_o.eof  = (left_q == 8'd1);
            cmd_o.cnt  = PieceBytes;
            cmd_o.data = {piece_mode_i, piece_ticks_i, {(CmdBytes*8-24){1'b0}}};
            left_d     = left_q - 8'd1;
            open_d     = (left_q != 8'd1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

@@ rtl/core/pefs_queue.sv @@
// Short command queue between front and back, built from flops.
// Depends on pefs_pkg.
module pefs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pefs_pkg::cmd_t     push_cmd_i,
  input  logic               pop_i,
  output pefs_pkg::cmd_t     head_o,
  output pefs_pkg::q_stat_t  stat_o
);
  import pefs_pkg::*;

  localparam int unsigned PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  cmd_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == CountW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

endmodule

@@ rtl/core/pefs_back.sv @@
// Back end: serializes one command a byte per cycle with escape stuffing
// into a registered output stage, when not stalled. Depends on pefs_pkg.
module pefs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pefs_pkg::cmd_t     head_i,
  input  pefs_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               frame_end_o,
  output logic               last_o
);
  import pefs_pkg::*;

  logic                  busy_q, busy_d;
  logic                  sof_q, sof_d;
  logic                  eof_q, eof_d;
  logic                  esc_q, esc_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CmdBytes*8-1:0] data_q, data_d;
  logic                  ov_q, ov_d;
  logic [7:0]            ob_q, ob_d;
  logic                  oe_q, oe_d;
  logic                  ol_q, ol_d;
  logic                  emit, done;
  logic [7:0]            cur, sym;
  logic                  sym_end;

  assign emit = busy_q && (!ov_q || out_ready_i);
  assign cur  = data_q[CmdBytes*8-1 -: 8];

  always_comb begin
    sof_d   = sof_q;
    eof_d   = eof_q;
    esc_d   = esc_q;
    cnt_d   = cnt_q;
    data_d  = data_q;
    busy_d  = busy_q;
    sym     = cur;
    sym_end = 1'b0;
    if (emit) begin
      priority if (sof_q) begin
        sym   = ByteSof;
        sof_d = 1'b0;
      end else if (cnt_q != '0) begin
        if (esc_q) begin
          sym    = cur ^ ByteFlip;
          esc_d  = 1'b0;
          data_d = {data_q[CmdBytes*8-9:0], 8'h00};
          cnt_d  = cnt_q - CntW'(1);
        end else if (cur == ByteSof || cur == ByteEof) begin
          // hold the byte, send the escape first
          sym   = ByteEsc;
          esc_d = 1'b1;
        end else begin
          data_d = {data_q[CmdBytes*8-9:0], 8'h00};
          cnt_d  = cnt_q - CntW'(1);
        end
      end else begin
        sym     = ByteEof;
        sym_end = 1'b1;
        eof_d   = 1'b0;
      end
    end
    done  = !sof_d && (cnt_d == '0) && !eof_d;
    pop_o = !q_stat_i.empty && (!busy_q || (emit && done));
    if (pop_o) begin
      busy_d = 1'b1;
      sof_d  = head_i.sof;
      eof_d  = head_i.eof;
      esc_d  = 1'b0;
      cnt_d  = head_i.cnt;
      data_d = head_i.data;
    end else if (emit && done) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    ov_d = ov_q;
    ob_d = ob_q;
    oe_d = oe_q;
    ol_d = ol_q;
    if (emit) begin
      ov_d = 1'b1;
      ob_d = sym;
      oe_d = sym_end;
      ol_d = done;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sof_q  <= 1'b0;
      eof_q  <= 1'b0;
      esc_q  <= 1'b0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      sof_q  <= sof_d;
      eof_q  <= eof_d;
      esc_q  <= esc_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    ob_q   <= ob_d;
    oe_q   <= oe_d;
    ol_q   <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign frame_end_o = oe_q;
  assign last_o      = ol_q;

endmodule

@@ verif/pefs_frame_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the pulse event frame serializer: watches the item and byte
// channels, predicts the stuffed frame bytes of every input transaction and
// compares them in order. Depends on pefs_pkg.
module pefs_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [15:0] evt_id_i,
  input  logic [7:0]  wait_trigger_i,
  input  logic [63:0] time_us_i,
  input  logic [7:0]  piece_count_i,
  input  logic [7:0]  piece_mode_i,
  input  logic [15:0] piece_ticks_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        frame_end_i,
  input  logic        last_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  import pefs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } frame_byte_t;

  frame_byte_t pending_bytes[$];
  frame_byte_t item_bytes[$];
  logic        frame_open = 1'b0;
  logic [7:0]  pieces_due = '0;
  int unsigned mismatches = 0;

  function automatic void put_data(input logic [7:0] b);
    if (b == ByteSof || b == ByteEof) begin
      item_bytes.push_back('{ByteEsc, 1'b0, 1'b0});
      item_bytes.push_back('{b ^ ByteFlip, 1'b0, 1'b0});
    end else begin
      item_bytes.push_back('{b, 1'b0, 1'b0});
    end
  endfunction

  // Append the bytes that one accepted item must produce, last flag on the final one.
  function automatic void serialize_item(input logic func, input logic [15:0] id,
                                         input logic [7:0] wt, input logic [63:0] tm,
                                         input logic [7:0] cnt, input logic [7:0] mode,
                                         input logic [15:0] ticks);
    frame_byte_t entry;
    int k;
    item_bytes.delete();
    if (func == FuncHeader) begin
      item_bytes.push_back('{ByteSof, 1'b0, 1'b0});
      put_data(id[15:8]);
      put_data(id[7:0]);
      put_data(wt);
      for (k = 7; k >= 0; k--) put_data(tm[8*k +: 8]);
      put_data(cnt);
      if (cnt == 8'd0) begin
        item_bytes.push_back('{ByteEof, 1'b1, 1'b0});
        frame_open = 1'b0;
        pieces_due = '0;
      end else begin
        frame_open = 1'b1;
        pieces_due = cnt;
      end
    end else if (frame_open) begin
      put_data(mode);
      put_data(ticks[15:8]);
      put_data(ticks[7:0]);
      pieces_due = pieces_due - 8'd1;
      if (pieces_due == 8'd0) begin
        item_bytes.push_back('{ByteEof, 1'b1, 1'b0});
        frame_open = 1'b0;
      end
    end
    for (k = 0; k < item_bytes.size(); k++) begin
      entry = item_bytes[k];
      entry.last = (k == item_bytes.size() - 1);
      pending_bytes.push_back(entry);
    end
  endfunction

  task automatic check_byte();
    frame_byte_t want;
    if (pending_bytes.size() == 0) begin
      $error("out_byte: no byte expected, got %h", out_byte_i);
      mismatches++;
    end else begin
      want = pending_bytes.pop_front();
      if (out_byte_i !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, out_byte_i);
        mismatches++;
      end
      if (frame_end_i !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, frame_end_i);
        mismatches++;
      end
      if (last_i !== want.last) begin
        $error("last: expected %b, got %b", want.last, last_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_bytes.delete();
      frame_open = 1'b0;
      pieces_due = '0;
    end else begin
      if (out_valid_i && out_ready_i) check_byte();
      if (in_valid_i && in_ready_i) begin
        serialize_item(func_i, evt_id_i, wait_trigger_i, time_us_i, piece_count_i,
                       piece_mode_i, piece_ticks_i);
      end
    end
    pending_o = pending_bytes.size();
    err_cnt_o = mismatches;
  end

endmodule

@@ verif/tb_pulse_event_frame_serializer.sv @@
`timescale 1ns / 100ps
// Top of the frame serializer testbench: clock, reset, header and piece
// stimulus with random pacing on both channels, and the verdict.
// Depends on pefs_pkg, pulse_event_frame_serializer and pefs_frame_checker.
module tb_pulse_event_frame_serializer;
  import pefs_pkg::*;

  localparam int unsigned ItemTarget = 410;
  localparam int unsigned CycleLimit = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FuncHeader;
  logic [15:0] evt_id = '0;
  logic [7:0]  wait_trigger = '0;
  logic [63:0] time_us = '0;
  logic [7:0]  piece_count = '0;
  logic [7:0]  piece_mode = '0;
  logic [15:0] piece_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        frame_end;
  logic        last;

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned ready_pick;
  bit          quiet_run = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pulse_event_frame_serializer i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .evt_id_i       (evt_id),
    .wait_trigger_i (wait_trigger),
    .time_us_i      (time_us),
    .piece_count_i  (piece_count),
    .piece_mode_i   (piece_mode),
    .piece_ticks_i  (piece_ticks),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .frame_end_o    (frame_end),
    .last_o         (last)
  );

  pefs_frame_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (func),
    .evt_id_i       (evt_id),
    .wait_trigger_i (wait_trigger),
    .time_us_i      (time_us),
    .piece_count_i  (piece_count),
    .piece_mode_i   (piece_mode),
    .piece_ticks_i  (piece_ticks),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_i     (out_byte),
    .frame_end_i    (frame_end),
    .last_i         (last),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Byte sink: bursts of ready, short stalls, rare long stalls and long open stretches.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 50) begin
        out_ready  <= 1'b1;
        stall_left <= $urandom_range(0, 8);
      end else if (ready_pick < 58) begin
        out_ready  <= 1'b1;
        stall_left <= $urandom_range(100, 300);
      end else if (ready_pick < 93) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Bias toward the start, end and escape codes so stuffing is hit often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return ByteSof;
      1:       return ByteEof;
      2:       return ByteEsc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] pick_time();
    logic [63:0] v;
    int k;
    for (k = 0; k < 8; k++) v[8*k +: 8] = pick_byte();
    return v;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one item at a rising edge and hold it until the transaction completes.
  task automatic send_item(input logic f, input logic [15:0] id, input logic [7:0] wt,
                           input logic [63:0] tm, input logic [7:0] cnt,
                           input logic [7:0] mode, input logic [15:0] ticks);
    bit took;
    in_valid     <= 1'b1;
    func         <= f;
    evt_id       <= id;
    wait_trigger <= wt;
    time_us      <= tm;
    piece_count  <= cnt;
    piece_mode   <= mode;
    piece_ticks  <= ticks;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_header(input logic [15:0] id, input logic [7:0] wt,
                             input logic [63:0] tm, input logic [7:0] cnt);
    send_item(FuncHeader, id, wt, tm, cnt, pick_byte(), {pick_byte(), pick_byte()});
  endtask

  task automatic send_piece(input logic [7:0] mode, input logic [15:0] ticks);
    send_item(FuncPiece, {pick_byte(), pick_byte()}, pick_byte(), pick_time(), pick_byte(),
              mode, ticks);
  endtask

  task automatic pace();
    int unsigned gap;
    gap = quiet_run ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned items;
    int unsigned n;
    int unsigned k;
    int unsigned r;
    int unsigned j;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // piece with no frame open: dropped
    send_piece(8'hFE, 16'hFFFF); pace();
    send_header(16'h0000, 8'h00, 64'h0, 8'd0); pace();
    // all-ones header opens a 255-piece frame
    send_header(16'hFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255); pace();
    send_piece(8'hFF, 16'hFFFF); pace();
    send_piece(8'hFE, 16'hFEFE); pace();
    send_piece(8'h00, 16'h0000); pace();
    // new header abandons the open frame
    send_header(16'hFEFF, 8'hFE, 64'h1BFE_FF00_20DF_FE01, 8'd1); pace();
    send_piece(8'h1B, 16'h00FF); pace();
    send_piece(8'hFF, 16'hFE00); pace();
    send_header(16'h1234, 8'h00, 64'h0123_4567_89AB_CDEF, 8'd2); pace();
    send_piece(8'h20, 16'hDEFE); pace();
    send_piece(8'hDF, 16'h1B20);
    drain();
    send_header(16'hFF00, 8'h1B, 64'hFEFE_FEFE_FFFF_FFFF, 8'd0); pace();
    send_header(16'h00FE, 8'hDE, 64'h8000_0000_0000_0001, 8'hFE); pace();
    send_piece(8'h80, 16'h8001); pace();

    items = 0;
    while (items < ItemTarget) begin
      quiet_run = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) n = $urandom_range(21, 255);
      else if (r < 14) n = 0;
      else if (r < 24) n = $urandom_range(7, 20);
      else n = $urandom_range(1, 6);
      k = n;
      if (n > 20 || (n > 0 && $urandom_range(0, 9) == 0))
        k = $urandom_range(0, (n - 1 < 6) ? n - 1 : 6);
      send_header({pick_byte(), pick_byte()}, pick_byte(), pick_time(), 8'(n));
      pace();
      items++;
      for (j = 0; j < k; j++) begin
        send_piece(pick_byte(), {pick_byte(), pick_byte()});
        pace();
        items++;
      end
      // stray pieces once the frame is closed
      if (k == n && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          send_piece(pick_byte(), {pick_byte(), pick_byte()});
          pace();
        end
      end
      if ($urandom_range(0, 15) == 0) drain();
    end

    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pefs_pkg.sv
rtl/core/pefs_front.sv
rtl/core/pefs_queue.sv
rtl/core/pefs_back.sv
rtl/core/pulse_event_frame_serializer.sv
verif/pefs_frame_checker.sv
verif/tb_pulse_event_frame_serializer.sv
